// ===== hw/rtl/bwp_pkg.sv =====
package bwp_pkg;

    localparam int WEIGHT_FRAC_BITS = 14;

    localparam int LANES  = 4;
    localparam int IDX_W  = 2;
    localparam int WEIGHT_W = 16;
    localparam int SUM_W  = 18;
    localparam int NUM_W  = 26;
    localparam int REM_W  = 25;
    localparam int DEN_W  = 18;
    localparam int BYTE_W = 8;
    localparam int TOT_W  = 10;
    localparam int ADJ_W  = 11;
    localparam int QUO_STEPS = 8;

    localparam int DEG_LIMIT = int'((64'd1 << WEIGHT_FRAC_BITS) / 64'd100000000);

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef weight_t [LANES-1:0] weight_vec_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef byte_t [LANES-1:0] byte_vec_t;

    typedef struct packed {
        logic              neg;
        logic              sat;
        logic [REM_W-1:0]  rem;
        logic [BYTE_W-1:0] quo;
    } lane_t;

    typedef struct packed {
        logic              deg;
        logic [IDX_W-1:0]  top;
        logic [REM_W-1:0]  dsh;
        lane_t [LANES-1:0] lane;
    } div_t;

endpackage

// ===== hw/rtl/bwp_front.sv =====
module bwp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  bwp_pkg::weight_vec_t up_w,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output bwp_pkg::div_t        dn_data
);

    typedef logic [bwp_pkg::NUM_W-1:0] num_t;

    logic                            a_valid_reg;
    bwp_pkg::weight_vec_t            a_w_reg;
    logic [bwp_pkg::SUM_W-1:0]       a_sum_reg;
    logic [bwp_pkg::SUM_W-1:0]       a_sum_next;
    logic                            a_ready;

    logic                            b_valid_reg;
    num_t [bwp_pkg::LANES-1:0]       b_num_reg;
    num_t [bwp_pkg::LANES-1:0]       b_num_next;
    logic [bwp_pkg::DEN_W-1:0]       b_den_reg;
    logic [bwp_pkg::DEN_W-1:0]       b_den_next;
    logic                            b_deg_reg;
    logic                            b_deg_next;
    logic [bwp_pkg::IDX_W-1:0]       b_top_reg;
    logic [bwp_pkg::IDX_W-1:0]       b_top_next;
    logic                            b_ready;

    logic                            c_valid_reg;
    bwp_pkg::div_t                   c_data_reg;
    bwp_pkg::div_t                   c_data_next;
    logic                            c_ready;

    localparam logic [bwp_pkg::SUM_W-1:0] DEG_LIM = bwp_pkg::SUM_W'(bwp_pkg::DEG_LIMIT);

    assign c_ready  = !c_valid_reg || dn_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;
    assign dn_valid = c_valid_reg;
    assign dn_data  = c_data_reg;

    always_comb begin
        a_sum_next = '0;
        for (int i = 0; i < bwp_pkg::LANES; i++) begin
            a_sum_next = a_sum_next + {{(bwp_pkg::SUM_W - bwp_pkg::WEIGHT_W){up_w[i][15]}},
                                       up_w[i]};
        end
    end

    always_comb begin
        num_t wx;
        num_t sx;
        sx = {{(bwp_pkg::NUM_W - bwp_pkg::SUM_W){a_sum_reg[bwp_pkg::SUM_W-1]}}, a_sum_reg};
        for (int i = 0; i < bwp_pkg::LANES; i++) begin
            wx = {{(bwp_pkg::NUM_W - bwp_pkg::WEIGHT_W){a_w_reg[i][15]}}, a_w_reg[i]};
            b_num_next[i] = (wx << 9) - (wx << 1) + sx;
        end
        b_den_next = {a_sum_reg[bwp_pkg::SUM_W-2:0], 1'b0};
        b_deg_next = a_sum_reg[bwp_pkg::SUM_W-1] || (a_sum_reg <= DEG_LIM);
        b_top_next = '0;
        for (int i = 1; i < bwp_pkg::LANES; i++) begin
            if ($signed(a_w_reg[i]) > $signed(a_w_reg[b_top_next])) begin
                b_top_next = bwp_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        c_data_next.deg = b_deg_reg;
        c_data_next.top = b_top_reg;
        c_data_next.dsh = {b_den_reg[bwp_pkg::REM_W-8:0], 7'b0};
        for (int i = 0; i < bwp_pkg::LANES; i++) begin
            c_data_next.lane[i].neg = b_num_reg[i][bwp_pkg::NUM_W-1];
            c_data_next.lane[i].sat = !b_num_reg[i][bwp_pkg::NUM_W-1] &&
                                      (b_num_reg[i] >= {b_den_reg, 8'b0});
            c_data_next.lane[i].rem = b_num_reg[i][bwp_pkg::REM_W-1:0];
            c_data_next.lane[i].quo = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) a_valid_reg <= up_valid;
            if (b_ready) b_valid_reg <= a_valid_reg;
            if (c_ready) c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && a_ready) begin
            a_w_reg   <= up_w;
            a_sum_reg <= a_sum_next;
        end
        if (a_valid_reg && b_ready) begin
            b_num_reg <= b_num_next;
            b_den_reg <= b_den_next;
            b_deg_reg <= b_deg_next;
            b_top_reg <= b_top_next;
        end
        if (b_valid_reg && c_ready) begin
            c_data_reg <= c_data_next;
        end
    end

endmodule

// ===== hw/rtl/bwp_div_step.sv =====
module bwp_div_step (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          up_valid,
    output logic          up_ready,
    input  bwp_pkg::div_t up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output bwp_pkg::div_t dn_data
);

    logic          valid_reg;
    bwp_pkg::div_t data_reg;
    bwp_pkg::div_t data_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb begin
        logic hit;
        data_next     = up_data;
        data_next.dsh = up_data.dsh >> 1;
        for (int i = 0; i < bwp_pkg::LANES; i++) begin
            hit = up_data.lane[i].rem >= up_data.dsh;
            if (hit) begin
                data_next.lane[i].rem = up_data.lane[i].rem - up_data.dsh;
            end
            data_next.lane[i].quo = {up_data.lane[i].quo[bwp_pkg::BYTE_W-2:0], hit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/bwp_back.sv =====
module bwp_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          up_valid,
    output logic          up_ready,
    input  bwp_pkg::div_t up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output logic [31:0]   dn_packed,
    output logic          dn_deg
);

    logic                          f_valid_reg;
    bwp_pkg::byte_vec_t            f_byte_reg;
    bwp_pkg::byte_vec_t            f_byte_next;
    logic [bwp_pkg::TOT_W-1:0]     f_total_reg;
    logic [bwp_pkg::TOT_W-1:0]     f_total_next;
    logic [bwp_pkg::IDX_W-1:0]     f_top_reg;
    logic                          f_deg_reg;
    logic                          f_ready;

    logic                          o_valid_reg;
    logic [31:0]                   o_packed_reg;
    logic [31:0]                   o_packed_next;
    logic                          o_deg_reg;
    logic                          o_ready;

    assign o_ready   = !o_valid_reg || dn_ready;
    assign f_ready   = !f_valid_reg || o_ready;
    assign up_ready  = f_ready;
    assign dn_valid  = o_valid_reg;
    assign dn_packed = o_packed_reg;
    assign dn_deg    = o_deg_reg;

    always_comb begin
        f_total_next = '0;
        for (int i = 0; i < bwp_pkg::LANES; i++) begin
            if (up_data.lane[i].neg) begin
                f_byte_next[i] = '0;
            end else if (up_data.lane[i].sat) begin
                f_byte_next[i] = bwp_pkg::BYTE_MAX;
            end else begin
                f_byte_next[i] = up_data.lane[i].quo;
            end
            f_total_next = f_total_next + bwp_pkg::TOT_W'(f_byte_next[i]);
        end
    end

    always_comb begin
        logic [bwp_pkg::ADJ_W-1:0] adj;
        bwp_pkg::byte_vec_t        fixed;
        adj = bwp_pkg::ADJ_W'(f_byte_reg[f_top_reg]) + bwp_pkg::ADJ_W'(bwp_pkg::BYTE_MAX)
            - bwp_pkg::ADJ_W'(f_total_reg);
        fixed = f_byte_reg;
        if (adj[bwp_pkg::ADJ_W-1]) begin
            fixed[f_top_reg] = '0;
        end else if (adj[bwp_pkg::ADJ_W-2:bwp_pkg::BYTE_W] != '0) begin
            fixed[f_top_reg] = bwp_pkg::BYTE_MAX;
        end else begin
            fixed[f_top_reg] = adj[bwp_pkg::BYTE_W-1:0];
        end
        if (f_deg_reg) begin
            o_packed_next = 32'(bwp_pkg::BYTE_MAX);
        end else begin
            o_packed_next = fixed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (f_ready) f_valid_reg <= up_valid;
            if (o_ready) o_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && f_ready) begin
            f_byte_reg  <= f_byte_next;
            f_total_reg <= f_total_next;
            f_top_reg   <= up_data.top;
            f_deg_reg   <= up_data.deg;
        end
        if (f_valid_reg && o_ready) begin
            o_packed_reg <= o_packed_next;
            o_deg_reg    <= f_deg_reg;
        end
    end

endmodule

// ===== hw/rtl/blend_weight_unorm8_packer_unit.sv =====
// Blend weight packer: four signed Q2.14 skinning weights in, one word of four
// unorm8 weights out, each weight normalized by the sum of the four.
// Input word: s_weight0..s_weight3 under s_valid / s_ready.
// Output word: m_packed_weights (weight0 in bits 7:0) and m_degenerate under
// m_valid / m_ready. m_degenerate is set, with m_packed_weights = 255, when the
// weight sum is not positive.
// A word accepted at s_valid / s_ready passes through thirteen register stages:
// three setup stages (sum, numerators, range flags), eight restoring divide
// stages that each resolve one quotient bit for all four weights, and two
// stages for the residue fixup and packing. Throughput is one word per cycle
// while m_ready does not hold the output back.
// Every stage holds its own valid bit and ready is passed back stage by stage,
// so while the receiver stalls the pipeline keeps filling its empty stages and
// s_ready drops only once every stage holds a word. No word is lost or
// repeated across a stall.
// Synchronous active-low reset clears all valid bits, so every stage is empty
// and s_ready is high once reset is released.
module blend_weight_unorm8_packer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_weight0,
    input  logic [15:0] s_weight1,
    input  logic [15:0] s_weight2,
    input  logic [15:0] s_weight3,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_packed_weights,
    output logic        m_degenerate
);

    bwp_pkg::weight_vec_t in_w;
    bwp_pkg::div_t        st_data  [0:bwp_pkg::QUO_STEPS];
    logic                 st_valid [0:bwp_pkg::QUO_STEPS];
    logic                 st_ready [0:bwp_pkg::QUO_STEPS];

    assign in_w[0] = s_weight0;
    assign in_w[1] = s_weight1;
    assign in_w[2] = s_weight2;
    assign in_w[3] = s_weight3;

    bwp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_valid),
        .up_ready (s_ready),
        .up_w     (in_w),
        .dn_valid (st_valid[0]),
        .dn_ready (st_ready[0]),
        .dn_data  (st_data[0])
    );

    for (genvar k = 0; k < bwp_pkg::QUO_STEPS; k++) begin : g_div
        bwp_div_step u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (st_valid[k]),
            .up_ready (st_ready[k]),
            .up_data  (st_data[k]),
            .dn_valid (st_valid[k+1]),
            .dn_ready (st_ready[k+1]),
            .dn_data  (st_data[k+1])
        );
    end

    bwp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .up_valid  (st_valid[bwp_pkg::QUO_STEPS]),
        .up_ready  (st_ready[bwp_pkg::QUO_STEPS]),
        .up_data   (st_data[bwp_pkg::QUO_STEPS]),
        .dn_valid  (m_valid),
        .dn_ready  (m_ready),
        .dn_packed (m_packed_weights),
        .dn_deg    (m_degenerate)
    );

endmodule

// ===== hw/rtl/bwp_check.sv =====
module bwp_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_packed_weights,
    input logic        m_degenerate
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packed_weights) && $stable(m_degenerate))
        else $error("output word changed while stalled");

    a_deg_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_packed_weights == 32'd255)
        else $error("degenerate word is not 255");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input held off while the output side drains");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind blend_weight_unorm8_packer_unit bwp_check u_bwp_check (.*);
